### hdl/set_assoc_lru_cache_tags_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the cache tag block
// Immediate-implication and next-cycle-implication checks on clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_LRU_CACHE_TAGS_MACROS_SVH
`define SET_ASSOC_LRU_CACHE_TAGS_MACROS_SVH

`define SAC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define SAC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/sac_pkg.sv
// ----------------------------------------------------------------------------
// Cache tag package
// Shared constants, codes and controller/datapath command and status types.
// ----------------------------------------------------------------------------
`default_nettype none

package sac_pkg;

  localparam int unsigned DEF_MAX_WAYS     = 8;
  localparam int unsigned DEF_MAX_SET_BITS = 10;
  localparam int unsigned WORD_BYTES       = 4;
  localparam int unsigned WORD_SHIFT       = $clog2(WORD_BYTES);
  localparam int unsigned MIN_OFFSET_BITS  = 2;
  localparam int unsigned MAX_OFFSET_BITS  = 8;

  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned FETCH_W    = 7;
  localparam int unsigned MEMW_W     = 21;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 4;

  localparam logic [ADDR_W-1:0] ADDR_ONES = 32'hFFFF_FFFF;

  typedef enum logic [KIND_W-1:0] {
    KIND_DLOAD  = 2'd0,
    KIND_DSTORE = 2'd1,
    KIND_ILOAD  = 2'd2,
    KIND_FLUSH  = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPLIT_MODE  = 3'd0,
    CFG_WRITE_BACK  = 3'd1,
    CFG_WRITE_ALLOC = 3'd2,
    CFG_WAYS        = 3'd3,
    CFG_OFFSET      = 3'd4,
    CFG_FIRST_SETS  = 3'd5,
    CFG_SECOND_SETS = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic clear;
    logic accept;
    logic finish;
    logic flush_step;
    logic load_flush;
  } sac_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic in_flush;
    logic flush_done;
  } sac_stat_t;

endpackage

`default_nettype wire

### hdl/sac_in_if.sv
// ----------------------------------------------------------------------------
// Access input channel
// Valid/ready channel carrying the access kind and byte address.
// ----------------------------------------------------------------------------
`default_nettype none

interface sac_in_if
  import sac_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output kind, output address, input ready);
  modport sink (input valid, input kind, input address, output ready);
endinterface

`default_nettype wire

### hdl/sac_out_if.sv
// ----------------------------------------------------------------------------
// Access result channel
// Valid/ready channel carrying the per-access cache outcome.
// ----------------------------------------------------------------------------
`default_nettype none

interface sac_out_if
  import sac_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               hit;
  logic               evicted;
  logic [FETCH_W-1:0] fetch_words;
  logic [MEMW_W-1:0]  memory_write_words;
  logic               is_data_stream;

  modport source (output valid, output hit, output evicted, output fetch_words,
                  output memory_write_words, output is_data_stream, input ready);
  modport sink (input valid, input hit, input evicted, input fetch_words,
                input memory_write_words, input is_data_stream, output ready);
endinterface

`default_nettype wire

### hdl/set_assoc_lru_cache_tags.sv
// An access reads its set row on acceptance and registers its result once the output is free;
// a flush walks the set rows, reading one row per cycle from the tag memory, and registers
// its result once the walk is done and the output is free. No new item is taken before then.
// The set-row memory has separate read and write ports (one read, one write per cycle).
// Reset is synchronous; afterwards a clearing pass over all 2^(MAX_SET_BITS+1) set rows
// (2048 by default) zeroes valid, dirty and LRU state before the first item is taken.
`default_nettype none
`include "set_assoc_lru_cache_tags_macros.svh"

// ----------------------------------------------------------------------------
// Set-associative LRU cache tag block
// Tag, valid, dirty and LRU state of a unified or split cache, one result per item.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_tags
  import sac_pkg::*;
#(
  parameter int unsigned MAX_WAYS     = DEF_MAX_WAYS,
  parameter int unsigned MAX_SET_BITS = DEF_MAX_SET_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  sac_in_if.sink                     in_chan,
  sac_out_if.source                  out_chan
);

  sac_cmd_t  cmd;
  sac_stat_t stat;
  logic      in_ready_w;
  logic      out_valid_w;
  logic      in_acc;
  logic      res_load;

  assign in_chan.ready  = in_ready_w;
  assign out_chan.valid = out_valid_w;
  assign in_acc         = in_chan.valid && in_ready_w;
  assign res_load       = cmd.finish || cmd.load_flush;

  sac_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_ready_w),
    .out_valid (out_valid_w),
    .out_ready (out_chan.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sac_dp #(
    .MAX_WAYS     (MAX_WAYS),
    .MAX_SET_BITS (MAX_SET_BITS)
  ) u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data),
    .in_kind                (in_chan.kind),
    .in_address             (in_chan.address),
    .cmd                    (cmd),
    .stat                   (stat),
    .out_hit                (out_chan.hit),
    .out_evicted            (out_chan.evicted),
    .out_fetch_words        (out_chan.fetch_words),
    .out_memory_write_words (out_chan.memory_write_words),
    .out_is_data_stream     (out_chan.is_data_stream)
  );

  `SAC_ASSERT_NXT(a_busy_after_accept, in_acc, !in_ready_w, "item accepted while busy")
  `SAC_ASSERT_IMP(a_no_overwrite, res_load, !out_valid_w || out_chan.ready, "result overwritten")
  `SAC_ASSERT_NXT(a_result_shown, res_load, out_valid_w, "loaded result not presented")

endmodule

`default_nettype wire

### hdl/sac_ctrl.sv
// ----------------------------------------------------------------------------
// Cache tag controller
// Sequences the clearing pass, single accesses and flush walks.
// ----------------------------------------------------------------------------
`default_nettype none

module sac_ctrl
  import sac_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire sac_stat_t stat,
  output sac_cmd_t       cmd
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS,
    ST_FLUSH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  always_comb begin
    out_free       = !out_valid_r || out_ready;
    in_ready       = (state_r == ST_IDLE);
    cmd.clear      = (state_r == ST_CLEAR);
    cmd.accept     = in_ready && in_valid;
    cmd.finish     = (state_r == ST_ACCESS) && out_free;
    cmd.flush_step = (state_r == ST_FLUSH);
    cmd.load_flush = (state_r == ST_FLUSH) && stat.flush_done && out_free;
    out_valid      = out_valid_r;

    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (stat.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd.accept) begin
          state_nxt = stat.in_flush ? ST_FLUSH : ST_ACCESS;
        end
      end
      ST_ACCESS: begin
        if (cmd.finish) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (cmd.load_flush) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase

    if (cmd.finish || cmd.load_flush) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

### hdl/sac_dp.sv
// ----------------------------------------------------------------------------
// Cache tag datapath
// Configuration registers, set-row tag memory, LRU update and flush counter.
// ----------------------------------------------------------------------------
`default_nettype none

module sac_dp
  import sac_pkg::*;
#(
  parameter int unsigned MAX_WAYS     = DEF_MAX_WAYS,
  parameter int unsigned MAX_SET_BITS = DEF_MAX_SET_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic [KIND_W-1:0]     in_kind,
  input  wire logic [ADDR_W-1:0]     in_address,
  input  wire sac_cmd_t              cmd,
  output sac_stat_t                  stat,
  output logic                       out_hit,
  output logic                       out_evicted,
  output logic [FETCH_W-1:0]         out_fetch_words,
  output logic [MEMW_W-1:0]          out_memory_write_words,
  output logic                       out_is_data_stream
);

  localparam int unsigned SET_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int unsigned ROW_AW = SET_W + 1;
  localparam int unsigned ROWS   = 2 ** ROW_AW;
  localparam int unsigned WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned RANK_W = WAY_W;
  localparam int unsigned FLC_W  = ROW_AW + WAY_W + 1;
  localparam int unsigned FLW_W  = FLC_W + MAX_OFFSET_BITS - WORD_SHIFT;

  localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_WAYS - 1);

  logic                  split_r, wb_r, walloc_r;
  logic [CFG_DATA_W-1:0] ways_r, off_r, sets1_r, sets2_r;

  logic [4:0]            ways_eff;
  logic [3:0]            off_eff, sb1_eff, sb2_eff, sb_in, sb_fl;
  logic [2:0]            bw_shift;
  logic [FETCH_W-1:0]    block_words;
  logic [MAX_WAYS-1:0]   wmask;

  logic                  in_is_data, in_arr;
  logic [SET_W-1:0]      set_in;
  logic [4:0]            tag_shift;
  logic [ADDR_W-1:0]     tag_in;

  logic [KIND_W-1:0]     kind_r;
  logic [ADDR_W-1:0]     tag_r;
  logic [ROW_AW-1:0]     row_r;
  logic                  is_data_r;

  logic [MAX_WAYS-1:0][ADDR_W-1:0] tag_mem [ROWS];
  logic [MAX_WAYS-1:0]             vld_mem [ROWS];
  logic [MAX_WAYS-1:0]             dty_mem [ROWS];
  logic [MAX_WAYS-1:0][RANK_W-1:0] rank_mem [ROWS];

  logic [MAX_WAYS-1:0][ADDR_W-1:0] rd_tag_r;
  logic [MAX_WAYS-1:0]             rd_vld_r, rd_dty_r;
  logic [MAX_WAYS-1:0][RANK_W-1:0] rd_rank_r;

  logic                  rd_en;
  logic [ROW_AW-1:0]     rd_addr;
  logic                  mem_we;
  logic [ROW_AW-1:0]     wr_addr;
  logic [MAX_WAYS-1:0]   wr_vld, wr_dty;
  logic [MAX_WAYS-1:0][RANK_W-1:0] wr_rank;

  logic [ROW_AW-1:0]     clr_ptr_r;

  logic [ROW_AW-1:0]     fl_ptr_r, fl_ptr_nxt;
  logic                  fl_more_r, fl_more_nxt, fl_pend_r;
  logic [FLC_W-1:0]      fl_cnt_r;
  logic [WAY_W:0]        fl_pop;
  logic [SET_W-1:0]      fl_last;
  logic [FLW_W-1:0]      fl_words;

  logic [MAX_WAYS-1:0]             v, n_vld, n_dty;
  logic [MAX_WAYS-1:0][RANK_W-1:0] n_rank;
  logic [MAX_WAYS-1:0][ADDR_W-1:0] n_tag;
  logic                  found_any, free_any, vic_any, is_store;
  logic [WAY_W-1:0]      found, free_w, vic, line;
  logic [RANK_W-1:0]     vic_rank, old_rank;
  logic                  a_hit, a_evict;
  logic [FETCH_W-1:0]    a_fetch;
  logic [MEMW_W-1:0]     a_mem;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      split_r  <= 1'b0;
      wb_r     <= 1'b1;
      walloc_r <= 1'b1;
      ways_r   <= 4'd1;
      off_r    <= 4'd4;
      sets1_r  <= 4'd6;
      sets2_r  <= 4'd6;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SPLIT_MODE:  split_r  <= cfg_data[0];
        CFG_WRITE_BACK:  wb_r     <= cfg_data[0];
        CFG_WRITE_ALLOC: walloc_r <= cfg_data[0];
        CFG_WAYS:        ways_r   <= cfg_data;
        CFG_OFFSET:      off_r    <= cfg_data;
        CFG_FIRST_SETS:  sets1_r  <= cfg_data;
        CFG_SECOND_SETS: sets2_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (ways_r == '0) begin
      ways_eff = 5'd1;
    end else if ({1'b0, ways_r} > 5'(MAX_WAYS)) begin
      ways_eff = 5'(MAX_WAYS);
    end else begin
      ways_eff = {1'b0, ways_r};
    end
    if (off_r < 4'(MIN_OFFSET_BITS)) begin
      off_eff = 4'(MIN_OFFSET_BITS);
    end else if (off_r > 4'(MAX_OFFSET_BITS)) begin
      off_eff = 4'(MAX_OFFSET_BITS);
    end else begin
      off_eff = off_r;
    end
    sb1_eff     = (sets1_r > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS) : sets1_r;
    sb2_eff     = (sets2_r > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS) : sets2_r;
    bw_shift    = 3'(off_eff - 4'(WORD_SHIFT));
    block_words = FETCH_W'(1) << bw_shift;
    for (int w = 0; w < MAX_WAYS; w++) begin
      wmask[w] = (5'(w) < ways_eff);
    end

    in_is_data = (kind_t'(in_kind) != KIND_ILOAD);
    in_arr     = split_r && in_is_data;
    sb_in      = in_arr ? sb2_eff : sb1_eff;
    set_in     = SET_W'(in_address >> off_eff) & ~({SET_W{1'b1}} << sb_in);
    tag_shift  = {1'b0, off_eff} + {1'b0, sb_in};
    tag_in     = in_address & (ADDR_ONES << tag_shift);

    stat.in_flush = (kind_t'(in_kind) == KIND_FLUSH);
    stat.clr_last = (clr_ptr_r == {ROW_AW{1'b1}});
    stat.flush_done = !fl_more_r && !fl_pend_r;
  end

  // Flush walk over the rows of the first array, then of the second in split mode.
  always_comb begin
    sb_fl       = fl_ptr_r[SET_W] ? sb2_eff : sb1_eff;
    fl_last     = ~({SET_W{1'b1}} << sb_fl);
    fl_ptr_nxt  = fl_ptr_r;
    fl_more_nxt = fl_more_r;
    if (fl_ptr_r[SET_W-1:0] == fl_last) begin
      if (!fl_ptr_r[SET_W] && split_r) begin
        fl_ptr_nxt = {1'b1, {SET_W{1'b0}}};
      end else begin
        fl_more_nxt = 1'b0;
      end
    end else begin
      fl_ptr_nxt = fl_ptr_r + 1'b1;
    end
    fl_pop = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      fl_pop = fl_pop + (WAY_W + 1)'(rd_vld_r[w] & rd_dty_r[w] & wmask[w]);
    end
    fl_words = FLW_W'(fl_cnt_r) << bw_shift;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_ptr_r <= '0;
      fl_more_r <= 1'b0;
      fl_pend_r <= 1'b0;
    end else begin
      if (cmd.clear) begin
        clr_ptr_r <= clr_ptr_r + 1'b1;
      end
      if (cmd.accept) begin
        fl_more_r <= 1'b1;
        fl_pend_r <= 1'b0;
      end else if (cmd.flush_step) begin
        fl_pend_r <= fl_more_r;
        if (fl_more_r) begin
          fl_more_r <= fl_more_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r    <= in_kind;
      tag_r     <= tag_in;
      row_r     <= {in_arr, set_in};
      is_data_r <= in_is_data;
      fl_ptr_r  <= '0;
      fl_cnt_r  <= '0;
    end else if (cmd.flush_step) begin
      if (fl_more_r) begin
        fl_ptr_r <= fl_ptr_nxt;
      end
      if (fl_pend_r) begin
        fl_cnt_r <= fl_cnt_r + FLC_W'(fl_pop);
      end
    end
  end

  always_comb begin
    v         = rd_vld_r & wmask;
    found_any = 1'b0;
    found     = '0;
    free_any  = 1'b0;
    free_w    = '0;
    vic_any   = 1'b0;
    vic       = '0;
    vic_rank  = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (v[w]) begin
        if (!found_any && (rd_tag_r[w] == tag_r)) begin
          found_any = 1'b1;
          found     = WAY_W'(w);
        end
        if (!vic_any || (rd_rank_r[w] > vic_rank)) begin
          vic_any  = 1'b1;
          vic      = WAY_W'(w);
          vic_rank = rd_rank_r[w];
        end
      end else if (wmask[w] && !free_any) begin
        free_any = 1'b1;
        free_w   = WAY_W'(w);
      end
    end

    is_store = (kind_t'(kind_r) == KIND_DSTORE);
    n_vld    = rd_vld_r;
    n_dty    = rd_dty_r;
    n_rank   = rd_rank_r;
    n_tag    = rd_tag_r;
    a_hit    = 1'b0;
    a_evict  = 1'b0;
    a_fetch  = '0;
    a_mem    = '0;
    old_rank = rd_rank_r[found];
    line     = free_any ? free_w : vic;

    if (found_any) begin
      a_hit = 1'b1;
      for (int w = 0; w < MAX_WAYS; w++) begin
        if (v[w] && (WAY_W'(w) != found) && (rd_rank_r[w] < old_rank)) begin
          n_rank[w] = (rd_rank_r[w] < RANK_MAX) ? rd_rank_r[w] + 1'b1 : rd_rank_r[w];
        end
      end
      n_rank[found] = '0;
      if (is_store) begin
        if (wb_r) begin
          n_dty[found] = 1'b1;
        end else begin
          n_dty[found] = 1'b0;
          a_mem        = MEMW_W'(1);
        end
      end
    end else if (is_store && !walloc_r) begin
      a_mem = MEMW_W'(1);
    end else begin
      a_fetch = block_words;
      if (!free_any) begin
        a_evict = 1'b1;
        if (rd_dty_r[line]) begin
          a_mem = MEMW_W'(block_words);
        end
        n_vld[line] = 1'b0;
      end
      for (int w = 0; w < MAX_WAYS; w++) begin
        if (n_vld[w] && wmask[w]) begin
          n_rank[w] = (rd_rank_r[w] < RANK_MAX) ? rd_rank_r[w] + 1'b1 : rd_rank_r[w];
        end
      end
      n_tag[line]  = tag_r;
      n_vld[line]  = 1'b1;
      n_rank[line] = '0;
      n_dty[line]  = is_store && wb_r;
      if (is_store && !wb_r) begin
        a_mem = a_mem + MEMW_W'(1);
      end
    end
  end

  always_comb begin
    rd_en   = cmd.accept || (cmd.flush_step && fl_more_r);
    rd_addr = cmd.accept ? {in_arr, set_in} : fl_ptr_r;
    mem_we  = cmd.clear || cmd.finish;
    wr_addr = cmd.clear ? clr_ptr_r : row_r;
    wr_vld  = cmd.clear ? '0 : n_vld;
    wr_dty  = cmd.clear ? '0 : n_dty;
    wr_rank = cmd.clear ? '0 : n_rank;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      vld_mem[wr_addr]  <= wr_vld;
      dty_mem[wr_addr]  <= wr_dty;
      rank_mem[wr_addr] <= wr_rank;
    end
    if (cmd.finish) begin
      tag_mem[row_r] <= n_tag;
    end
    if (rd_en) begin
      rd_tag_r  <= tag_mem[rd_addr];
      rd_vld_r  <= vld_mem[rd_addr];
      rd_dty_r  <= dty_mem[rd_addr];
      rd_rank_r <= rank_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_hit                <= a_hit;
      out_evicted            <= a_evict;
      out_fetch_words        <= a_fetch;
      out_memory_write_words <= a_mem;
      out_is_data_stream     <= is_data_r;
    end else if (cmd.load_flush) begin
      out_hit                <= 1'b0;
      out_evicted            <= 1'b0;
      out_fetch_words        <= '0;
      out_memory_write_words <= MEMW_W'(fl_words);
      out_is_data_stream     <= 1'b1;
    end
  end

endmodule

`default_nettype wire

### test/sac_checker.sv
// ----------------------------------------------------------------------------
// Cache tag outcome checker
// Watches the configuration port and both channels, keeps its own tag, valid,
// dirty and LRU state, predicts the outcome of every accepted access and
// compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module sac_checker
  import sac_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  sac_in_if                     in_mon,
  sac_out_if                    out_mon,
  output int                    fail_count,
  output int                    pending,
  output int                    result_count
);

  localparam int unsigned WAYS_N  = DEF_MAX_WAYS;
  localparam int unsigned SETS_N  = 1 << DEF_MAX_SET_BITS;
  localparam int unsigned ARRAY_N = SETS_N * WAYS_N;

  typedef struct packed {
    logic               hit;
    logic               evicted;
    logic [FETCH_W-1:0] fetch_words;
    logic [MEMW_W-1:0]  memory_write_words;
    logic               is_data_stream;
  } outcome_t;

  logic [ADDR_W-1:0] tag_mem   [2*ARRAY_N];
  logic              valid_mem [2*ARRAY_N];
  logic              dirty_mem [2*ARRAY_N];
  logic [2:0]        rank_mem  [2*ARRAY_N];

  logic       split_q, wback_q, walloc_q;
  logic [3:0] ways_q, off_q, sets1_q, sets2_q;

  outcome_t expected_q[$];

  function automatic int unsigned ways_eff();
    if (ways_q < 1) return 1;
    if (ways_q > WAYS_N) return WAYS_N;
    return ways_q;
  endfunction

  function automatic int unsigned off_eff();
    if (off_q < MIN_OFFSET_BITS) return MIN_OFFSET_BITS;
    if (off_q > MAX_OFFSET_BITS) return MAX_OFFSET_BITS;
    return off_q;
  endfunction

  function automatic int unsigned sets_eff(logic [3:0] v);
    return (v > DEF_MAX_SET_BITS) ? DEF_MAX_SET_BITS : v;
  endfunction

  function automatic logic [2:0] age(logic [2:0] r);
    return (r < WAYS_N - 1) ? r + 3'd1 : r;
  endfunction

  function automatic int unsigned dirty_words(int unsigned arr, int unsigned blk);
    int unsigned total, nsets, i;
    total = 0;
    nsets = 1 << sets_eff(arr ? sets2_q : sets1_q);
    for (int unsigned s = 0; s < nsets; s++) begin
      for (int unsigned w = 0; w < ways_eff(); w++) begin
        i = arr * ARRAY_N + s * WAYS_N + w;
        if (valid_mem[i] && dirty_mem[i]) total += blk;
      end
    end
    return total;
  endfunction

  function automatic outcome_t access_outcome(kind_t kind, logic [ADDR_W-1:0] addr);
    outcome_t res;
    int unsigned off, blk, ways, arr, sb, set_i, base, found, freew, victim, line, i;
    logic [ADDR_W-1:0] tag;
    logic [2:0] old;
    logic store;
    off = off_eff();
    blk = (1 << off) / WORD_BYTES;
    ways = ways_eff();
    res = '0;
    found = WAYS_N;
    freew = WAYS_N;
    victim = WAYS_N;
    store = (kind == KIND_DSTORE);
    if (kind == KIND_FLUSH) begin
      i = dirty_words(0, blk);
      if (split_q) i += dirty_words(1, blk);
      res.memory_write_words = i[MEMW_W-1:0];
      res.is_data_stream = 1'b1;
      return res;
    end
    res.is_data_stream = (kind != KIND_ILOAD);
    arr = (split_q && res.is_data_stream) ? 1 : 0;
    sb = sets_eff(arr ? sets2_q : sets1_q);
    set_i = (addr >> off) & ((1 << sb) - 1);
    tag = addr & (ADDR_ONES << (off + sb));
    base = arr * ARRAY_N + set_i * WAYS_N;
    for (int unsigned w = 0; w < ways; w++) begin
      i = base + w;
      if (valid_mem[i]) begin
        if (found == WAYS_N && tag_mem[i] == tag) found = w;
        if (victim == WAYS_N || rank_mem[i] > rank_mem[base + victim]) victim = w;
      end else if (freew == WAYS_N) begin
        freew = w;
      end
    end
    if (found != WAYS_N) begin
      res.hit = 1'b1;
      old = rank_mem[base + found];
      for (int unsigned w = 0; w < ways; w++) begin
        i = base + w;
        if (valid_mem[i] && w != found && rank_mem[i] < old) rank_mem[i] = age(rank_mem[i]);
      end
      line = base + found;
      rank_mem[line] = '0;
      if (store) begin
        if (wback_q) begin
          dirty_mem[line] = 1'b1;
        end else begin
          dirty_mem[line] = 1'b0;
          res.memory_write_words = 1;
        end
      end
    end else if (store && !walloc_q) begin
      res.memory_write_words = 1;
    end else begin
      res.fetch_words = blk[FETCH_W-1:0];
      if (freew != WAYS_N) begin
        line = base + freew;
      end else begin
        line = base + victim;
        res.evicted = 1'b1;
        if (dirty_mem[line]) res.memory_write_words += blk;
        valid_mem[line] = 1'b0;
      end
      for (int unsigned w = 0; w < ways; w++) begin
        i = base + w;
        if (valid_mem[i]) rank_mem[i] = age(rank_mem[i]);
      end
      tag_mem[line] = tag;
      valid_mem[line] = 1'b1;
      rank_mem[line] = '0;
      dirty_mem[line] = 1'b0;
      if (store) begin
        if (wback_q) dirty_mem[line] = 1'b1;
        else res.memory_write_words += 1;
      end
    end
    return res;
  endfunction

  task automatic report(string field, int unsigned got, int unsigned exp);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, field, got, exp);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    result_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    outcome_t got, exp;
    if (!rst_n) begin
      for (int i = 0; i < 2 * ARRAY_N; i++) begin
        valid_mem[i] = 1'b0;
        dirty_mem[i] = 1'b0;
        rank_mem[i] = '0;
      end
      split_q = 1'b0; wback_q = 1'b1; walloc_q = 1'b1;
      ways_q = 4'd1; off_q = 4'd4; sets1_q = 4'd6; sets2_q = 4'd6;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_SPLIT_MODE:  split_q = cfg_data[0];
          CFG_WRITE_BACK:  wback_q = cfg_data[0];
          CFG_WRITE_ALLOC: walloc_q = cfg_data[0];
          CFG_WAYS:        ways_q = cfg_data;
          CFG_OFFSET:      off_q = cfg_data;
          CFG_FIRST_SETS:  sets1_q = cfg_data;
          CFG_SECOND_SETS: sets2_q = cfg_data;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        expected_q.push_back(access_outcome(kind_t'(in_mon.kind), in_mon.address));
      if (out_mon.valid && out_mon.ready) begin
        result_count++;
        got = '{out_mon.hit, out_mon.evicted, out_mon.fetch_words,
                out_mon.memory_write_words, out_mon.is_data_stream};
        if (expected_q.size() == 0) begin
          report("items outstanding", 1, 0);
        end else begin
          exp = expected_q.pop_front();
          if (got.hit !== exp.hit) report("hit", got.hit, exp.hit);
          if (got.evicted !== exp.evicted) report("evicted", got.evicted, exp.evicted);
          if (got.fetch_words !== exp.fetch_words)
            report("fetch_words", got.fetch_words, exp.fetch_words);
          if (got.memory_write_words !== exp.memory_write_words)
            report("memory_write_words", got.memory_write_words, exp.memory_write_words);
          if (got.is_data_stream !== exp.is_data_stream)
            report("is_data_stream", got.is_data_stream, exp.is_data_stream);
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// Cache tag block testbench
// Drives directed and pooled random accesses through several cache
// configurations with random gaps and stalls; the checker judges results.
// ----------------------------------------------------------------------------
module tb;
  import sac_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int PHASE_ITEMS = 180;
  localparam int N_PHASES = 7;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    fail_count, pending, result_count;
  int                    sent = 0;
  int                    idle_cycles = 0;
  bit                    no_gaps = 1'b0;
  int unsigned           cur_off = 4, cur_sets = 6;
  logic [ADDR_W-1:0]     addr_pool[12];

  // split, write_back, write_alloc, ways, offset, first sets, second sets
  logic [3:0] phase_cfg[N_PHASES][7] = '{
    '{1, 1, 1, 8, 4, 2, 1},
    '{0, 0, 0, 4, 2, 0, 0},
    '{1, 0, 1, 15, 15, 10, 3},
    '{1, 1, 0, 0, 0, 15, 0},
    '{0, 1, 1, 2, 8, 3, 10},
    '{1, 0, 0, 8, 5, 1, 2},
    '{0, 1, 1, 3, 3, 4, 4}
  };

  sac_in_if  in_if ();
  sac_out_if out_if ();

  set_assoc_lru_cache_tags dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  sac_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_mon      (in_if),
    .out_mon     (out_if),
    .fail_count  (fail_count),
    .pending     (pending),
    .result_count(result_count)
  );

  always #2 clk = ~clk;

  initial begin
    in_if.valid = 1'b0;
    in_if.kind = KIND_DLOAD;
    in_if.address = '0;
    out_if.ready = 1'b0;
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      stall = no_gaps ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        out_if.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_if.ready = 1'b1;
      do @(posedge clk); while (!out_if.valid);
    end
  end

  task automatic send(kind_t kind, logic [ADDR_W-1:0] addr);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.kind = kind;
    in_if.address = addr;
    in_if.valid = 1'b1;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
    sent++;
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [3:0] value);
    cfg_index = idx;
    cfg_data = value;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic drain();
    in_if.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  function automatic kind_t pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 38) return KIND_DLOAD;
    if (r < 70) return KIND_DSTORE;
    if (r < 96) return KIND_ILOAD;
    return KIND_FLUSH;
  endfunction

  function automatic logic [ADDR_W-1:0] pool_addr();
    logic [ADDR_W-1:0] a;
    a = addr_pool[$urandom_range(0, 11)];
    return a ^ ($urandom & ((32'd1 << cur_off) - 1));
  endfunction

  initial begin
    kind_t k;
    int unsigned off_raw;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Default configuration: one way, 16-byte blocks, 64 sets, write-back.
    send(KIND_DLOAD, 32'h0000_0000);
    send(KIND_DLOAD, 32'h0000_0004);
    send(KIND_DSTORE, 32'h0000_0008);
    send(KIND_FLUSH, 32'h0000_0000);
    send(KIND_DLOAD, 32'h0000_0400);
    send(KIND_DLOAD, ADDR_ONES);
    send(KIND_DSTORE, ADDR_ONES);
    send(KIND_ILOAD, 32'h1234_5670);
    send(KIND_DSTORE, 32'h0000_0800);
    send(KIND_ILOAD, 32'h0000_0800);
    send(KIND_FLUSH, ADDR_ONES);
    send(KIND_DSTORE, 32'hFFFF_FC0F);
    send(KIND_ILOAD, 32'hAAAA_5555);
    send(KIND_DLOAD, 32'h5555_AAAA);
    send(KIND_FLUSH, 32'h0000_0000);
    drain();

    for (int p = 0; p < N_PHASES; p++) begin
      write_reg(CFG_SPLIT_MODE, phase_cfg[p][0]);
      write_reg(CFG_WRITE_BACK, phase_cfg[p][1]);
      write_reg(CFG_WRITE_ALLOC, phase_cfg[p][2]);
      write_reg(CFG_WAYS, phase_cfg[p][3]);
      write_reg(CFG_OFFSET, phase_cfg[p][4]);
      write_reg(CFG_FIRST_SETS, phase_cfg[p][5]);
      write_reg(CFG_SECOND_SETS, phase_cfg[p][6]);
      off_raw = phase_cfg[p][4];
      cur_off = (off_raw < 2) ? 2 : (off_raw > 8) ? 8 : off_raw;
      cur_sets = (phase_cfg[p][5] > phase_cfg[p][6]) ? phase_cfg[p][5] : phase_cfg[p][6];
      if (cur_sets > 10) cur_sets = 10;
      foreach (addr_pool[i])
        addr_pool[i] = ($urandom & (ADDR_ONES << (cur_off + cur_sets)))
                       | ($urandom_range(0, 3) << cur_off);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 60 == 0) no_gaps = ($urandom_range(0, 2) == 0);
        k = pick_kind();
        send(k, ($urandom_range(0, 9) == 0) ? $urandom : pool_addr());
      end
      no_gaps = 1'b0;
      drain();
    end

    $display("Ran %0d accesses over %0d configurations; %0d results compared.",
             sent, N_PHASES + 1, result_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches found.", fail_count);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
